>>> hdl/fsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller package
// Shared types, register indexes, event and status codes, and constants.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Width of the millisecond tick counters.
  localparam int TIME_BITS = 32;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_MS     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PWM_TOP       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PULSES_TO_RPM = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_RPM_LIMIT = 3'd4;

  localparam logic [7:0]  DEBOUNCE_MS_RST   = 8'd50;
  localparam logic [15:0] WINDOW_MS_RST     = 16'd1000;
  localparam logic [7:0]  PWM_TOP_RST       = 8'd199;
  localparam logic [7:0]  PULSES_TO_RPM_RST = 8'd30;
  localparam logic [15:0] LOW_RPM_LIMIT_RST = 16'd2640;

  // Event kinds.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_ENCODER = 2'd2;
  localparam logic [1:0] KIND_PULSE   = 2'd3;

  // Encoder pin patterns (bit 1 channel A, bit 0 channel B).
  localparam logic [1:0] ENC_REST   = 2'b00;
  localparam logic [1:0] ENC_B_ONLY = 2'b01;
  localparam logic [1:0] ENC_A_ONLY = 2'b10;

  // Fan status codes.
  localparam logic [1:0] STATUS_OFF     = 2'd0;
  localparam logic [1:0] STATUS_STOPPED = 2'd1;
  localparam logic [1:0] STATUS_LOW     = 2'd2;
  localparam logic [1:0] STATUS_OK      = 2'd3;

  // Duty limits and reset value.
  localparam logic [6:0] DUTY_MIN = 7'd1;
  localparam logic [6:0] DUTY_MAX = 7'd100;
  localparam logic [6:0] DUTY_RST = 7'd50;

  // Division by 100 of a product below 25600: (x * 5243) >> 19 is exact.
  localparam int         PROD_BITS   = 15;
  localparam int         RECIP_BITS  = 28;
  localparam int         RECIP_SHIFT = 19;
  localparam logic [RECIP_BITS-1:0] RECIP_100 = 28'd5243;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] encoder_ab;
  } in_word_t;

  typedef struct packed {
    logic       fan_enabled;
    logic [6:0] duty_percent;
    logic [7:0] compare_value;
    logic [15:0] rpm_value;
    logic [1:0] fan_status;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] window_ms;
    logic [7:0]  pwm_top;
    logic [7:0]  pulses_to_rpm;
    logic [15:0] low_rpm_limit;
  } cfg_t;

  // State after one event, handed from the update stage to the result stage.
  typedef struct packed {
    logic                 fan_enabled;
    logic [6:0]           duty_percent;
    logic [PROD_BITS-1:0] product;
    logic [15:0]          rpm_value;
  } snap_t;

endpackage

>>> hdl/fsc_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller state update
// Input register, event decode and controller state; emits a snapshot.
// ----------------------------------------------------------------------------
module fsc_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsc_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fsc_pkg::in_word_t in_word_i,
  output logic              snap_valid_o,
  input  logic              snap_ready_i,
  output fsc_pkg::snap_t    snap_o
);

  logic                        ina_valid_q;
  fsc_pkg::in_word_t           ina_q;
  logic                        snap_valid_q;
  fsc_pkg::snap_t              snap_q;
  logic                        a_fire;

  // Elapsed times since the last accepted press and since the window start.
  logic [fsc_pkg::TIME_BITS-1:0] since_press_q, since_press_d;
  logic [fsc_pkg::TIME_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                          enabled_q, enabled_d;
  logic [6:0]                    duty_q, duty_d;
  logic [1:0]                    enc_last_q, enc_last_d;
  logic [15:0]                   pulses_q, pulses_d;
  logic [15:0]                   rpm_q, rpm_d;
  logic [23:0]                   rpm_raw;
  logic [fsc_pkg::PROD_BITS-1:0] product;

  assign a_fire     = ina_valid_q && (!snap_valid_q || snap_ready_i);
  assign in_ready_o = !ina_valid_q || a_fire;

  assign elapsed_inc = elapsed_q + 1'b1;
  assign rpm_raw     = {8'd0, pulses_q} * {16'd0, cfg_i.pulses_to_rpm};

  always_comb begin
    since_press_d = since_press_q;
    elapsed_d     = elapsed_q;
    enabled_d     = enabled_q;
    duty_d        = duty_q;
    enc_last_d    = enc_last_q;
    pulses_d      = pulses_q;
    rpm_d         = rpm_q;
    case (ina_q.kind)
      fsc_pkg::KIND_TICK: begin
        since_press_d = since_press_q + 1'b1;
        if (elapsed_inc >= {{(fsc_pkg::TIME_BITS-16){1'b0}}, cfg_i.window_ms}) begin
          rpm_d     = (|rpm_raw[23:16]) ? 16'hFFFF : rpm_raw[15:0];
          pulses_d  = '0;
          elapsed_d = '0;
        end else begin
          elapsed_d = elapsed_inc;
        end
      end
      fsc_pkg::KIND_PRESS: begin
        if (since_press_q > {{(fsc_pkg::TIME_BITS-8){1'b0}}, cfg_i.debounce_ms}) begin
          enabled_d     = !enabled_q;
          since_press_d = '0;
        end
      end
      fsc_pkg::KIND_ENCODER: begin
        if (enabled_q && (ina_q.encoder_ab != enc_last_q)) begin
          if (ina_q.encoder_ab == fsc_pkg::ENC_REST) begin
            if (enc_last_q == fsc_pkg::ENC_A_ONLY && duty_q < fsc_pkg::DUTY_MAX) begin
              duty_d = duty_q + 7'd1;
            end else if (enc_last_q == fsc_pkg::ENC_B_ONLY &&
                         duty_q > fsc_pkg::DUTY_MIN) begin
              duty_d = duty_q - 7'd1;
            end
          end
          enc_last_d = ina_q.encoder_ab;
        end
      end
      fsc_pkg::KIND_PULSE: begin
        if (pulses_q != 16'hFFFF) begin
          pulses_d = pulses_q + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign product = enabled_d ? ({8'd0, duty_d} * {7'd0, cfg_i.pwm_top}) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ina_valid_q   <= 1'b0;
      snap_valid_q  <= 1'b0;
      since_press_q <= '0;
      elapsed_q     <= '0;
      enabled_q     <= 1'b1;
      duty_q        <= fsc_pkg::DUTY_RST;
      enc_last_q    <= fsc_pkg::ENC_REST;
      pulses_q      <= '0;
      rpm_q         <= '0;
    end else begin
      if (in_ready_o) begin
        ina_valid_q <= in_valid_i;
      end
      snap_valid_q <= a_fire || (snap_valid_q && !snap_ready_i);
      if (a_fire) begin
        since_press_q <= since_press_d;
        elapsed_q     <= elapsed_d;
        enabled_q     <= enabled_d;
        duty_q        <= duty_d;
        enc_last_q    <= enc_last_d;
        pulses_q      <= pulses_d;
        rpm_q         <= rpm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ina_q <= in_word_i;
    end
    if (a_fire) begin
      snap_q <= '{fan_enabled: enabled_d, duty_percent: duty_d,
                  product: product, rpm_value: rpm_d};
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q >= fsc_pkg::DUTY_MIN && duty_q <= fsc_pkg::DUTY_MAX)
    else $error("duty setting left its range");

  a_off_no_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && !snap_q.fan_enabled |-> snap_q.product == '0)
    else $error("product nonzero while fan is off");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ina_valid_q && snap_valid_q && !snap_ready_i)
    else $error("input stalled with room downstream");

endmodule

>>> hdl/fsc_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller result stage
// Scales the duty product by 1/100, derives status, holds the output word.
// ----------------------------------------------------------------------------
module fsc_result (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsc_pkg::cfg_t      cfg_i,
  input  logic               snap_valid_i,
  output logic               snap_ready_o,
  input  fsc_pkg::snap_t     snap_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fsc_pkg::out_word_t out_word_o
);

  logic                           out_valid_q;
  fsc_pkg::out_word_t             out_q;
  logic [fsc_pkg::RECIP_BITS-1:0] scaled;
  logic [1:0]                     status;
  logic                           b_fire;

  assign snap_ready_o = !out_valid_q || out_ready_i;
  assign b_fire       = snap_valid_i && snap_ready_o;

  assign scaled = {{(fsc_pkg::RECIP_BITS-fsc_pkg::PROD_BITS){1'b0}}, snap_i.product}
                  * fsc_pkg::RECIP_100;

  always_comb begin
    if (!snap_i.fan_enabled) begin
      status = fsc_pkg::STATUS_OFF;
    end else if (snap_i.rpm_value == 16'd0) begin
      status = fsc_pkg::STATUS_STOPPED;
    end else if (snap_i.rpm_value < cfg_i.low_rpm_limit) begin
      status = fsc_pkg::STATUS_LOW;
    end else begin
      status = fsc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= b_fire || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_q <= '{fan_enabled: snap_i.fan_enabled, duty_percent: snap_i.duty_percent,
                 compare_value: scaled[fsc_pkg::RECIP_SHIFT +: 8],
                 rpm_value: snap_i.rpm_value, fan_status: status};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_off_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.fan_enabled |->
      out_q.compare_value == 8'd0 && out_q.fan_status == fsc_pkg::STATUS_OFF)
    else $error("fan off but compare or status not cleared");

  a_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.fan_enabled |-> out_q.fan_status != fsc_pkg::STATUS_OFF)
    else $error("fan on but status reports off");

endmodule

>>> hdl/fan_speed_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller top level
// Event-driven PWM fan controller with button toggle, encoder duty control
// and tachometer based rpm measurement.
// ----------------------------------------------------------------------------
//
// Channel   Signals                              Word
// --------  -----------------------------------  ---------------------------
// input     in_valid_i / in_ready_o / in_word_i  kind, encoder_ab
// output    out_valid_o / out_ready_i / out_word_o  enabled, duty, compare,
//                                                 rpm, status
// config    cfg_we_i / cfg_idx_i / cfg_wdata_i   one register per write
//
// Every accepted word produces exactly one output word. The path is three
// register stages deep (input register, update stage, output register); one
// word per cycle is sustained while out_ready_i stays high. The update stage
// holds one 16x8 rpm multiplier and one 7x8 duty multiplier; the result stage
// does the divide by 100 as a constant multiplication. Reset is asynchronous
// and active low; it restores the valid flags, the controller state and the
// configuration to their documented values and empties the pipeline; the
// data word registers are not reset. A stall at the output backs up stage
// by stage; in_ready_o drops only when all stages are full.
//
module fan_speed_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fsc_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fsc_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_we_i,
  input  logic [fsc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [fsc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);

  // Configuration registers. The user must change them only while the block
  // is idle; the block itself does not enforce this. Both stages read them directly.
  fsc_pkg::cfg_t  cfg_q;

  logic           snap_valid;
  logic           snap_ready;
  fsc_pkg::snap_t snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= fsc_pkg::DEBOUNCE_MS_RST;
      cfg_q.window_ms     <= fsc_pkg::WINDOW_MS_RST;
      cfg_q.pwm_top       <= fsc_pkg::PWM_TOP_RST;
      cfg_q.pulses_to_rpm <= fsc_pkg::PULSES_TO_RPM_RST;
      cfg_q.low_rpm_limit <= fsc_pkg::LOW_RPM_LIMIT_RST;
    end else if (cfg_we_i) begin
      // Writes to an index beyond the register list are dropped.
      case (cfg_idx_i)
        fsc_pkg::CFG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_wdata_i[7:0];
        fsc_pkg::CFG_WINDOW_MS:     cfg_q.window_ms     <= cfg_wdata_i;
        fsc_pkg::CFG_PWM_TOP:       cfg_q.pwm_top       <= cfg_wdata_i[7:0];
        fsc_pkg::CFG_PULSES_TO_RPM: cfg_q.pulses_to_rpm <= cfg_wdata_i[7:0];
        fsc_pkg::CFG_LOW_RPM_LIMIT: cfg_q.low_rpm_limit <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Event decode and state update; the snapshot carries the state after the
  // event together with the duty times top product, zero while the fan is off.
  fsc_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // Compare scaling, status and the output register.
  fsc_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

>>> test/fan_speed_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller testbench
// Drives event words into the controller and checks every result word against
// a cycle-free model of the controller state kept in the testbench. Runs
// directed events first, then random events under several register settings
// and back-pressure patterns.
// ----------------------------------------------------------------------------
module fan_speed_controller_top_test;

  localparam int PIPE_DEPTH    = 3;
  localparam int SETTLE_CYCLES = 4 * PIPE_DEPTH;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_WORDS  = 250;
  localparam int IDX_BITS      = fsc_pkg::CFG_IDX_BITS;
  localparam int DATA_BITS     = fsc_pkg::CFG_DATA_BITS;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  fsc_pkg::in_word_t        in_word_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  fsc_pkg::out_word_t       out_word_o;
  logic                     cfg_we_i    = 1'b0;
  logic [IDX_BITS-1:0]      cfg_idx_i   = '0;
  logic [DATA_BITS-1:0]     cfg_wdata_i = '0;

  fan_speed_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Expected controller state, updated once per accepted input word.
  fsc_pkg::cfg_t                 regs;
  logic [fsc_pkg::TIME_BITS-1:0] ms_now;
  logic [fsc_pkg::TIME_BITS-1:0] last_press_ms;
  logic [fsc_pkg::TIME_BITS-1:0] window_open_ms;
  logic                          fan_on;
  logic [6:0]                    duty;
  logic [1:0]                    enc_prev;
  logic [15:0]                   tach_pulses;
  logic [15:0]                   rpm_hold;

  fsc_pkg::in_word_t  pending_words[$];
  fsc_pkg::out_word_t predicted_words[$];
  int                 error_count   = 0;
  int                 result_seq    = 0;
  int                 stall_cycles  = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  // Applies one event to the expected state and returns the word it shows.
  function automatic fsc_pkg::out_word_t advance_controller(fsc_pkg::in_word_t w);
    logic [fsc_pkg::TIME_BITS-1:0] elapsed;
    logic [31:0]                   rpm_raw;
    logic [15:0]                   duty_scaled;
    fsc_pkg::out_word_t            r;
    case (w.kind)
      fsc_pkg::KIND_TICK: begin
        ms_now  = ms_now + 1'b1;
        elapsed = ms_now - window_open_ms;
        // The window closes only on a tick; a zero window closes every tick.
        if (elapsed >= regs.window_ms) begin
          rpm_raw        = 32'(tach_pulses) * 32'(regs.pulses_to_rpm);
          rpm_hold       = (rpm_raw > 32'hFFFF) ? 16'hFFFF : rpm_raw[15:0];
          tach_pulses    = '0;
          window_open_ms = ms_now;
        end
      end
      fsc_pkg::KIND_PRESS: begin
        elapsed = ms_now - last_press_ms;
        if (elapsed > regs.debounce_ms) begin
          fan_on        = !fan_on;
          last_press_ms = ms_now;
        end
      end
      fsc_pkg::KIND_ENCODER: begin
        // A switched-off fan ignores the encoder and keeps the old pin state.
        if (fan_on && w.encoder_ab != enc_prev) begin
          if (w.encoder_ab == fsc_pkg::ENC_REST) begin
            if (enc_prev == fsc_pkg::ENC_A_ONLY && duty < fsc_pkg::DUTY_MAX) begin
              duty = duty + 1'b1;
            end else if (enc_prev == fsc_pkg::ENC_B_ONLY && duty > fsc_pkg::DUTY_MIN) begin
              duty = duty - 1'b1;
            end
          end
          enc_prev = w.encoder_ab;
        end
      end
      fsc_pkg::KIND_PULSE: begin
        if (tach_pulses != 16'hFFFF) begin
          tach_pulses = tach_pulses + 1'b1;
        end
      end
      default: begin
      end
    endcase
    duty_scaled     = 16'(duty) * 16'(regs.pwm_top);
    r.fan_enabled   = fan_on;
    r.duty_percent  = duty;
    r.compare_value = fan_on ? 8'(duty_scaled / 16'd100) : 8'd0;
    r.rpm_value     = rpm_hold;
    if (!fan_on) begin
      r.fan_status = fsc_pkg::STATUS_OFF;
    end else if (rpm_hold == '0) begin
      r.fan_status = fsc_pkg::STATUS_STOPPED;
    end else if (rpm_hold < regs.low_rpm_limit) begin
      r.fan_status = fsc_pkg::STATUS_LOW;
    end else begin
      r.fan_status = fsc_pkg::STATUS_OK;
    end
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      flag_error($sformatf("result %0d %s: got %0d, want %0d", result_seq, name, got, want));
    end
  endtask

  // Input driver: presents queued words with random gaps and predicts each
  // accepted word. The valid stays up until the word is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_words.push_back(advance_controller(in_word_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    fsc_pkg::out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_words.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: %h",
                               result_seq, out_word_o));
        end else begin
          want = predicted_words.pop_front();
          check_field("fan_enabled", out_word_o.fan_enabled, want.fan_enabled);
          check_field("duty_percent", out_word_o.duty_percent, want.duty_percent);
          check_field("compare_value", out_word_o.compare_value, want.compare_value);
          check_field("rpm_value", out_word_o.rpm_value, want.rpm_value);
          check_field("fan_status", out_word_o.fan_status, want.fan_status);
        end
        result_seq++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no word moves on any port for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("fan_speed_controller_top_test: errors");
        $finish;
      end
    end
  end

  task automatic push_word(logic [1:0] kind, logic [1:0] ab);
    fsc_pkg::in_word_t w;
    w.kind       = kind;
    w.encoder_ab = ab;
    pending_words.push_back(w);
  endtask

  // Waits until every queued word has gone in and every result has come out.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || predicted_words.size() != 0);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      fsc_pkg::CFG_DEBOUNCE_MS:   regs.debounce_ms   = val[7:0];
      fsc_pkg::CFG_WINDOW_MS:     regs.window_ms     = val;
      fsc_pkg::CFG_PWM_TOP:       regs.pwm_top       = val[7:0];
      fsc_pkg::CFG_PULSES_TO_RPM: regs.pulses_to_rpm = val[7:0];
      fsc_pkg::CFG_LOW_RPM_LIMIT: regs.low_rpm_limit = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] dbn, logic [15:0] win, logic [7:0] top,
                          logic [7:0] mult, logic [15:0] low);
    write_reg(fsc_pkg::CFG_DEBOUNCE_MS, 16'(dbn));
    write_reg(fsc_pkg::CFG_WINDOW_MS, win);
    write_reg(fsc_pkg::CFG_PWM_TOP, 16'(top));
    write_reg(fsc_pkg::CFG_PULSES_TO_RPM, 16'(mult));
    write_reg(fsc_pkg::CFG_LOW_RPM_LIMIT, low);
  endtask

  // Random events. Most encoder traffic is clean detent steps, sometimes long
  // sweeps that drive the duty into its limits; the rest is pin noise. Presses
  // follow a random run of up to the debounce time plus two ticks.
  task automatic add_random(int n);
    int base;
    int pick;
    int run;
    bit rising;
    base   = pending_words.size();
    rising = 1'b1;
    while (pending_words.size() - base < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        push_word(fsc_pkg::KIND_TICK, 2'($urandom));
      end else if (pick < 42) begin
        repeat ($urandom_range(int'(regs.debounce_ms) + 2)) begin
          push_word(fsc_pkg::KIND_TICK, 2'($urandom));
        end
        push_word(fsc_pkg::KIND_PRESS, 2'($urandom));
      end else if (pick < 75) begin
        if ($urandom_range(9) == 0) begin
          push_word(fsc_pkg::KIND_ENCODER, 2'($urandom));
        end else begin
          if ($urandom_range(3) == 0) begin
            rising = !rising;
          end
          run = ($urandom_range(24) == 0) ? $urandom_range(40, 110) : 1;
          repeat (run) begin
            push_word(fsc_pkg::KIND_ENCODER,
                      rising ? fsc_pkg::ENC_A_ONLY : fsc_pkg::ENC_B_ONLY);
            push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_REST);
          end
        end
      end else begin
        run = ($urandom_range(19) == 0) ? $urandom_range(50, 300) : 1;
        repeat (run) push_word(fsc_pkg::KIND_PULSE, 2'($urandom));
      end
    end
  endtask

  initial begin
    regs.debounce_ms   = fsc_pkg::DEBOUNCE_MS_RST;
    regs.window_ms     = fsc_pkg::WINDOW_MS_RST;
    regs.pwm_top       = fsc_pkg::PWM_TOP_RST;
    regs.pulses_to_rpm = fsc_pkg::PULSES_TO_RPM_RST;
    regs.low_rpm_limit = fsc_pkg::LOW_RPM_LIMIT_RST;
    ms_now             = '0;
    last_press_ms      = '0;
    window_open_ms     = '0;
    fan_on             = 1'b1;
    duty               = fsc_pkg::DUTY_RST;
    enc_prev           = fsc_pkg::ENC_REST;
    tach_pulses        = '0;
    rpm_hold           = '0;
    send_idle_pct      = 29;
    recv_idle_pct      = 65;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a press right after reset is too early, encoder steps
    // both ways, a non-detent pattern, and the pin field on other kinds.
    push_word(fsc_pkg::KIND_PRESS, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_A_ONLY);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_B_ONLY);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_ENCODER, 2'b11);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_PULSE, 2'b11);
    push_word(fsc_pkg::KIND_PULSE, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_TICK, 2'b11);
    push_word(fsc_pkg::KIND_PRESS, fsc_pkg::ENC_A_ONLY);
    drain();

    // No debounce, one-tick windows, largest scaling: toggle off, encoder
    // while off, a press in the same millisecond, toggle on, measure.
    set_regs(8'd0, 16'd1, 8'd255, 8'd255, 16'hFFFF);
    push_word(fsc_pkg::KIND_TICK, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_PRESS, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_A_ONLY);
    push_word(fsc_pkg::KIND_ENCODER, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_PRESS, 2'b11);
    push_word(fsc_pkg::KIND_TICK, fsc_pkg::ENC_B_ONLY);
    push_word(fsc_pkg::KIND_PRESS, fsc_pkg::ENC_REST);
    push_word(fsc_pkg::KIND_PULSE, fsc_pkg::ENC_A_ONLY);
    push_word(fsc_pkg::KIND_PULSE, fsc_pkg::ENC_B_ONLY);
    push_word(fsc_pkg::KIND_PULSE, 2'b11);
    push_word(fsc_pkg::KIND_TICK, fsc_pkg::ENC_REST);
    add_random(RANDOM_WORDS);
    drain();

    // Sender and receiver swap their idle rates from here on.
    send_idle_pct = 65;
    recv_idle_pct = 29;
    set_regs(8'd255, 16'hFFFF, 8'd1, 8'd1, 16'd0);
    add_random(RANDOM_WORDS);
    drain();

    // Zero window and zero top; writes to unused indexes must change nothing.
    set_regs(8'd3, 16'd0, 8'd0, 8'd7, 16'd100);
    for (int i = int'(fsc_pkg::CFG_LOW_RPM_LIMIT) + 1; i < (1 << IDX_BITS); i++) begin
      write_reg(IDX_BITS'(i), DATA_BITS'($urandom));
    end
    add_random(RANDOM_WORDS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(8'($urandom_range(20)), 16'($urandom_range(1, 30)), 8'($urandom_range(1, 255)),
             8'($urandom_range(1, 255)), 16'($urandom_range(2000)));
    add_random(RANDOM_WORDS);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("fan_speed_controller_top_test: clean");
    end else begin
      $display("fan_speed_controller_top_test: errors");
    end
    $finish;
  end

endmodule
